### rtl/ptc_pkg.sv
`default_nettype none

package ptc_pkg;

   // Field widths
   localparam int RAW_W = 20;
   localparam int DW    = 64;

   // Radix-2 divider: one quotient bit per stage
   localparam int DIV_STAGES = 64;

   // Register stages from the input transfer to the result register
   localparam int N_STAGES = 8 + 1 + DIV_STAGES + 4 + 1;

   // Compensation constants
   localparam int          T_FINE_OFFSET = 128000;
   localparam int          P_ADC_FULL    = 1048576;
   localparam logic [11:0] P_SCALE       = 12'd3125;
   localparam logic [63:0] A_BIAS        = 64'h0000_8000_0000_0000;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_TEMP    = 2'd0,
      CSR_PRESS_A = 2'd1,
      CSR_PRESS_B = 2'd2,
      CSR_PRESS_C = 2'd3
   } csr_index_type;

   // One divider stage: quotient bits shift in at the bottom of nq while
   // dividend bits shift out at the top
   typedef struct packed {
      logic [31:0] temp;
      logic        neg;
      logic        zero;
      logic [63:0] md;
      logic [63:0] rem;
      logic [63:0] nq;
   } div_stage_type;

endpackage

`default_nettype wire

### rtl/ptc_if.sv
`default_nettype none

// Raw sample channel
interface ptc_req_if import ptc_pkg::*;;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_pressure;
   logic [RAW_W-1:0] raw_temperature;
   modport source (output valid, output raw_pressure, output raw_temperature, input ready);
   modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// Compensated result channel
interface ptc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] temperature_centi;
   logic [31:0]        pressure_q24_8;
   logic               pressure_valid;
   modport source (output valid, output temperature_centi, output pressure_q24_8,
                   output pressure_valid, input ready);
   modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                   input pressure_valid, output ready);
endinterface

// Coefficient write channel
interface ptc_csr_if import ptc_pkg::*;;
   logic          valid;
   logic          ready;
   logic [1:0]    index;
   logic [DW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pressure_temperature_compensation_top.sv
`default_nettype none
// Throughput: one sample per cycle while no result waits on rsp_if; 78 register
// stages, set by the 64-stage radix-2 divider for the pressure quotient.
// The whole pipeline holds while a result waits on rsp_if.
// Reset (synchronous, active high) empties the pipeline and zeroes all
// coefficient registers.

module pressure_temperature_compensation_top import ptc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ptc_req_if.sink   req_if,
   ptc_rsp_if.source rsp_if,
   ptc_csr_if.sink   csr_if
);

   // Coefficient registers
   logic [47:0] temp_coeffs_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [15:0] press_c_ff;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coeffs_ff <= '0;
         press_a_ff     <= '0;
         press_b_ff     <= '0;
         press_c_ff     <= '0;
      end else if (csr_if.valid) begin
         case (csr_index_type'(csr_if.index))
            CSR_TEMP:    temp_coeffs_ff <= csr_if.data[47:0];
            CSR_PRESS_A: press_a_ff     <= csr_if.data;
            CSR_PRESS_B: press_b_ff     <= csr_if.data;
            CSR_PRESS_C: press_c_ff     <= csr_if.data[15:0];
            default: ;
         endcase
      end
   end

   logic        [15:0] t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

   assign t1 = temp_coeffs_ff[15:0];
   assign t2 = $signed(temp_coeffs_ff[31:16]);
   assign t3 = $signed(temp_coeffs_ff[47:32]);
   assign p1 = press_a_ff[15:0];
   assign p2 = $signed(press_a_ff[31:16]);
   assign p3 = $signed(press_a_ff[47:32]);
   assign p4 = $signed(press_a_ff[63:48]);
   assign p5 = $signed(press_b_ff[15:0]);
   assign p6 = $signed(press_b_ff[31:16]);
   assign p7 = $signed(press_b_ff[47:32]);
   assign p8 = $signed(press_b_ff[63:48]);
   assign p9 = $signed(press_c_ff);

   // Pipeline advance: everything holds while the result register is stuck
   logic                vld_ff [N_STAGES];
   logic                adv;

   assign adv          = !(vld_ff[N_STAGES-1] && !rsp_if.ready);
   assign req_if.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_STAGES; i++) vld_ff[i] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_if.valid;
         for (int i = 1; i < N_STAGES; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // Stage registers
   logic signed [33:0] v1p_s1_ff, v1p_s1_in;
   logic        [31:0] dd_s1_ff, dd_s1_in;
   logic  [RAW_W-1:0]  adcp_s1_ff, adcp_s2_ff, adcp_s3_ff, adcp_s4_ff, adcp_s5_ff, adcp_s6_ff;
   logic signed [22:0] v1_s2_ff, v1_s2_in;
   logic signed [36:0] v2p_s2_ff, v2p_s2_in;
   logic signed [23:0] tf_s3_ff, tf_s3_in;
   logic signed [24:0] a_s3_ff, a_s3_in;
   logic signed [49:0] aa_s4_ff, aa_s4_in;
   logic signed [40:0] ap5_s4_ff, ap5_s4_in, ap5_s5_ff;
   logic signed [40:0] ap2_s4_ff, ap2_s4_in, ap2_s5_ff;
   logic        [31:0] temp_s4_ff, temp_s4_in, temp_s5_ff, temp_s6_ff, temp_s7_ff, temp_s8_ff;
   logic signed [63:0] b1_s5_ff, b1_s5_in, aap3_s5_ff, aap3_s5_in;
   logic        [63:0] b_s6_ff, b_s6_in, a2_s6_ff, a2_s6_in;
   logic        [63:0] num0_s7_ff, num0_s7_in, a3p_s7_ff, a3p_s7_in;
   logic        [63:0] num_s8_ff, num_s8_in, a3p_s8_ff;
   div_stage_type      dv_ff [DIV_STAGES+1];
   div_stage_type      dv_in [DIV_STAGES+1];
   logic        [63:0] p_s10_ff, p_s10_in, p_s11_ff, p_s12_ff, p_s13_ff;
   logic        [31:0] temp_s10_ff, temp_s11_ff, temp_s12_ff, temp_s13_ff;
   logic               zero_s10_ff, zero_s11_ff, zero_s12_ff, zero_s13_ff;
   logic        [63:0] ll_s11_ff, ll_s11_in;
   logic        [31:0] cr_s11_ff, cr_s11_in;
   logic signed [63:0] p8p_s11_ff, p8p_s11_in;
   logic        [63:0] h2_s12_ff, h2_s12_in, e2_s12_ff, e2_s12_in, e2_s13_ff;
   logic signed [63:0] e1p_s13_ff, e1p_s13_in;
   logic        [31:0] temp_out_ff, press_out_ff, press_out_in;
   logic               pvalid_out_ff;

   // Combinational work between stages
   logic signed [17:0] d1, d2;
   logic signed [35:0] dd_full;
   logic signed [27:0] t5;
   logic signed [65:0] b1_full, aap3_full;
   logic        [63:0] a2u;
   logic        [79:0] a3p_full;
   logic        [75:0] num_full;
   logic signed [63:0] a3;
   logic signed [63:0] h;
   logic signed [79:0] p8p_full, e1p_full;
   logic        [63:0] sum;
   logic        [31:0] p7s;

   always_comb begin
      // s1: temperature differences and first products
      d1        = $signed({1'b0, req_if.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      d2        = $signed({2'b0, req_if.raw_temperature[19:4]}) - $signed({2'b0, t1});
      v1p_s1_in = d1 * t2;
      dd_full   = d2 * d2;
      dd_s1_in  = dd_full[31:0];

      // s2: v1 and the T3 product
      v1_s2_in  = v1p_s1_ff[33:11];
      v2p_s2_in = $signed({1'b0, dd_s1_ff[31:12]}) * t3;

      // s3: fine temperature and pressure offset
      tf_s3_in  = 24'(v1_s2_ff) + 24'($signed(v2p_s2_ff[36:14]));
      a_s3_in   = 25'(tf_s3_in) - 25'(T_FINE_OFFSET);

      // s4: square and first coefficient products, output temperature
      aa_s4_in   = a_s3_ff * a_s3_ff;
      ap5_s4_in  = a_s3_ff * p5;
      ap2_s4_in  = a_s3_ff * p2;
      t5         = tf_s3_ff * 28'sd5 + 28'sd128;
      temp_s4_in = 32'(t5 >>> 8);

      // s5: square times P6 and P3, wrapped to 64 bits
      b1_full    = aa_s4_ff * p6;
      aap3_full  = aa_s4_ff * p3;
      b1_s5_in   = b1_full[63:0];
      aap3_s5_in = aap3_full[63:0];

      // s6: offset b and the divisor sum
      b_s6_in  = b1_s5_ff + (64'(ap5_s5_ff) << 17) + (64'(p4) << 35);
      a2_s6_in = 64'(aap3_s5_ff >>> 8) + (64'(ap2_s5_ff) << 12);

      // s7: numerator before scaling, divisor times P1
      num0_s7_in = ((64'(P_ADC_FULL) - 64'(adcp_s6_ff)) << 31) - b_s6_ff;
      a2u        = a2_s6_ff + A_BIAS;
      a3p_full   = a2u * p1;
      a3p_s7_in  = a3p_full[63:0];

      // s8: numerator scaling
      num_full  = num0_s7_ff * P_SCALE;
      num_s8_in = num_full[63:0];

      // s9: magnitudes and signs into the divider
      a3           = $signed(a3p_s8_ff) >>> 33;
      dv_in[0].temp = temp_s8_ff;
      dv_in[0].neg  = num_s8_ff[63] ^ a3[63];
      dv_in[0].zero = (a3 == '0);
      dv_in[0].md   = a3[63] ? (64'd0 - a3) : a3;
      dv_in[0].rem  = '0;
      dv_in[0].nq   = num_s8_ff[63] ? (64'd0 - num_s8_ff) : num_s8_ff;

      // s10: quotient sign
      p_s10_in = dv_ff[DIV_STAGES].neg ? (64'd0 - dv_ff[DIV_STAGES].nq)
                                       : dv_ff[DIV_STAGES].nq;

      // s11: partial products of h*h, P8 term
      h          = $signed(p_s10_ff) >>> 13;
      ll_s11_in  = 64'(h[31:0]) * 64'(h[31:0]);
      cr_s11_in  = h[31:0] * h[63:32];
      p8p_full   = $signed(p_s10_ff) * p8;
      p8p_s11_in = p8p_full[63:0];

      // s12: h*h low word, P8 correction
      h2_s12_in = ll_s11_ff + {cr_s11_ff[30:0], 33'b0};
      e2_s12_in = 64'(p8p_s11_ff >>> 19);

      // s13: P9 term
      e1p_full   = $signed(h2_s12_ff) * p9;
      e1p_s13_in = e1p_full[63:0];

      // result: sum the corrections and add the P7 offset
      sum          = p_s13_ff + 64'(e1p_s13_ff >>> 25) + e2_s13_ff;
      p7s          = 32'(p7) << 4;
      press_out_in = zero_s13_ff ? 32'd0 : (sum[39:8] + p7s);
   end

   // Divider stages: one restoring step each
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [63:0] shl;
      always_comb begin
         shl            = {dv_ff[k].rem[62:0], dv_ff[k].nq[63]};
         dv_in[k+1]     = dv_ff[k];
         dv_in[k+1].nq  = {dv_ff[k].nq[62:0], 1'b0};
         if (shl >= dv_ff[k].md) begin
            dv_in[k+1].rem   = shl - dv_ff[k].md;
            dv_in[k+1].nq[0] = 1'b1;
         end else begin
            dv_in[k+1].rem   = shl;
         end
      end
   end

   // Data registers, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         v1p_s1_ff  <= v1p_s1_in;
         dd_s1_ff   <= dd_s1_in;
         adcp_s1_ff <= req_if.raw_pressure;

         v1_s2_ff   <= v1_s2_in;
         v2p_s2_ff  <= v2p_s2_in;
         adcp_s2_ff <= adcp_s1_ff;

         tf_s3_ff   <= tf_s3_in;
         a_s3_ff    <= a_s3_in;
         adcp_s3_ff <= adcp_s2_ff;

         aa_s4_ff   <= aa_s4_in;
         ap5_s4_ff  <= ap5_s4_in;
         ap2_s4_ff  <= ap2_s4_in;
         temp_s4_ff <= temp_s4_in;
         adcp_s4_ff <= adcp_s3_ff;

         b1_s5_ff   <= b1_s5_in;
         aap3_s5_ff <= aap3_s5_in;
         ap5_s5_ff  <= ap5_s4_ff;
         ap2_s5_ff  <= ap2_s4_ff;
         temp_s5_ff <= temp_s4_ff;
         adcp_s5_ff <= adcp_s4_ff;

         b_s6_ff    <= b_s6_in;
         a2_s6_ff   <= a2_s6_in;
         temp_s6_ff <= temp_s5_ff;
         adcp_s6_ff <= adcp_s5_ff;

         num0_s7_ff <= num0_s7_in;
         a3p_s7_ff  <= a3p_s7_in;
         temp_s7_ff <= temp_s6_ff;

         num_s8_ff  <= num_s8_in;
         a3p_s8_ff  <= a3p_s7_ff;
         temp_s8_ff <= temp_s7_ff;

         for (int i = 0; i <= DIV_STAGES; i++) dv_ff[i] <= dv_in[i];

         p_s10_ff    <= p_s10_in;
         temp_s10_ff <= dv_ff[DIV_STAGES].temp;
         zero_s10_ff <= dv_ff[DIV_STAGES].zero;

         p_s11_ff    <= p_s10_ff;
         ll_s11_ff   <= ll_s11_in;
         cr_s11_ff   <= cr_s11_in;
         p8p_s11_ff  <= p8p_s11_in;
         temp_s11_ff <= temp_s10_ff;
         zero_s11_ff <= zero_s10_ff;

         p_s12_ff    <= p_s11_ff;
         h2_s12_ff   <= h2_s12_in;
         e2_s12_ff   <= e2_s12_in;
         temp_s12_ff <= temp_s11_ff;
         zero_s12_ff <= zero_s11_ff;

         p_s13_ff    <= p_s12_ff;
         e1p_s13_ff  <= e1p_s13_in;
         e2_s13_ff   <= e2_s12_ff;
         temp_s13_ff <= temp_s12_ff;
         zero_s13_ff <= zero_s12_ff;

         temp_out_ff   <= temp_s13_ff;
         press_out_ff  <= press_out_in;
         pvalid_out_ff <= !zero_s13_ff;
      end
   end

   // Result channel
   assign rsp_if.valid             = vld_ff[N_STAGES-1];
   assign rsp_if.temperature_centi = $signed(temp_out_ff);
   assign rsp_if.pressure_q24_8    = press_out_ff;
   assign rsp_if.pressure_valid    = pvalid_out_ff;

endmodule

`default_nettype wire
